/* rtl/sidec_pkg.sv */
// ----------------------------------------------------------------------------
// sidec_pkg : shared definitions for the signed decimal ASCII converter
// Widths, character codes, the sequencer state type and the BCD digit
// adjust used by the shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
package sidec_pkg;

  // Digit buffer depth (1..19); fewer digits keeps only the low-order ones
  localparam int MAX_DIGITS = 19;

  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = DIGIT_W * MAX_DIGITS;
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Shift-and-add-3 correction for one BCD digit
  function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? (d + DIGIT_W'(3)) : d;
    return r;
  endfunction

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii : signed 64-bit integer to decimal ASCII text
// Bit-serial binary to BCD conversion followed by a digit-serial character
// stream, most significant digit first, with a leading minus for negatives.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+---------------------------
//  input   | in_value[63:0] (signed)                | start & !busy
//  result  | out_char_code[7:0], out_last_char      | out_valid strobe, 1 cycle
//
// Sequence: after a transaction is taken, the magnitude is shifted MSB
// first through the BCD register (one bit a cycle, all digits corrected in
// parallel). Then the minus sign on a negative value, then the MAX_DIGITS
// buffered digits in turn: leading zeros are shifted out silently, one
// per cycle, and every other digit is strobed out. busy is high from the
// conversion until the last digit; start is taken again in the cycle busy falls.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops any
// number in flight. The receiver cannot stall: each character is presented
// for exactly one cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transaction
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sidec_pkg::VALUE_W-1:0] in_value,
  // result transaction
  output logic                                 out_valid,
  output logic        [sidec_pkg::CHAR_W-1:0]  out_char_code,
  output logic                                 out_last_char
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  sidec_pkg::state_t                     state_r, state_nxt;
  logic [sidec_pkg::VALUE_W-1:0]         mag_r, mag_nxt;      // magnitude, shifted out MSB first
  logic [sidec_pkg::BCD_W-1:0]           bcd_r, bcd_nxt;      // BCD digits, top digit at MSB
  logic [sidec_pkg::BIT_CNT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [sidec_pkg::DIG_CNT_W-1:0]       dig_left_r, dig_left_nxt;
  logic                                  neg_r, neg_nxt;
  logic                                  ovf_r, ovf_nxt;      // magnitude exceeded the buffer
  logic                                  started_r, started_nxt;  // first digit already sent

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                                  accept;
  logic [sidec_pkg::VALUE_W-1:0]         raw;
  logic [sidec_pkg::BCD_W-1:0]           bcd_adj;
  logic [sidec_pkg::DIGIT_W-1:0]         top_digit;
  logic                                  conv_done;
  logic                                  skip_zero;
  logic                                  last_digit;

  assign accept    = start && !busy;
  assign raw       = $unsigned(in_value);
  assign top_digit = bcd_r[sidec_pkg::BCD_W-1 -: sidec_pkg::DIGIT_W];
  assign conv_done = (bit_cnt_r == sidec_pkg::BIT_CNT_W'(sidec_pkg::VALUE_W - 1));
  assign last_digit = (dig_left_r == sidec_pkg::DIG_CNT_W'(1));

  // Leading zero: dropped unless it is the only digit left or the number
  // overflowed the buffer (then every kept digit is printed).
  assign skip_zero = (top_digit == '0) && !started_r && !ovf_r && !last_digit;

  // Add-3 correction on every digit ahead of the shift
  always_comb begin
    for (int i = 0; i < sidec_pkg::MAX_DIGITS; i++) begin
      bcd_adj[i*sidec_pkg::DIGIT_W +: sidec_pkg::DIGIT_W] =
        sidec_pkg::bcd_adjust(bcd_r[i*sidec_pkg::DIGIT_W +: sidec_pkg::DIGIT_W]);
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sidec_pkg::ST_IDLE: begin
        if (start) state_nxt = sidec_pkg::ST_CONV;
      end
      sidec_pkg::ST_CONV: begin
        if (conv_done) state_nxt = neg_r ? sidec_pkg::ST_SIGN : sidec_pkg::ST_EMIT;
      end
      sidec_pkg::ST_SIGN: begin
        state_nxt = sidec_pkg::ST_EMIT;
      end
      sidec_pkg::ST_EMIT: begin
        if (last_digit) state_nxt = sidec_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sidec_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    mag_nxt      = mag_r;
    bcd_nxt      = bcd_r;
    bit_cnt_nxt  = bit_cnt_r;
    dig_left_nxt = dig_left_r;
    neg_nxt      = neg_r;
    ovf_nxt      = ovf_r;
    started_nxt  = started_r;
    case (state_r)
      sidec_pkg::ST_IDLE: begin
        if (accept) begin
          neg_nxt      = raw[sidec_pkg::VALUE_W-1];
          // two's complement magnitude; the most negative value stays 2^63
          mag_nxt      = raw[sidec_pkg::VALUE_W-1] ?
                         (~raw + sidec_pkg::VALUE_W'(1)) : raw;
          bcd_nxt      = '0;
          bit_cnt_nxt  = '0;
          dig_left_nxt = sidec_pkg::DIG_CNT_W'(sidec_pkg::MAX_DIGITS);
          ovf_nxt      = 1'b0;
          started_nxt  = 1'b0;
        end
      end
      sidec_pkg::ST_CONV: begin
        bcd_nxt     = {bcd_adj[sidec_pkg::BCD_W-2:0], mag_r[sidec_pkg::VALUE_W-1]};
        mag_nxt     = {mag_r[sidec_pkg::VALUE_W-2:0], 1'b0};
        ovf_nxt     = ovf_r | bcd_adj[sidec_pkg::BCD_W-1];
        bit_cnt_nxt = bit_cnt_r + sidec_pkg::BIT_CNT_W'(1);
      end
      sidec_pkg::ST_EMIT: begin
        bcd_nxt      = bcd_r << sidec_pkg::DIGIT_W;
        dig_left_nxt = dig_left_r - sidec_pkg::DIG_CNT_W'(1);
        if (!skip_zero) started_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy          = 1'b1;
    out_valid     = 1'b0;
    out_char_code = sidec_pkg::CHAR_ZERO + {{(sidec_pkg::CHAR_W - sidec_pkg::DIGIT_W){1'b0}},
                                            top_digit};
    out_last_char = 1'b0;
    case (state_r)
      sidec_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      sidec_pkg::ST_CONV: begin
      end
      sidec_pkg::ST_SIGN: begin
        out_valid     = 1'b1;
        out_char_code = sidec_pkg::CHAR_MINUS;
      end
      sidec_pkg::ST_EMIT: begin
        out_valid     = !skip_zero;
        out_last_char = last_digit;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sidec_pkg::ST_IDLE;
      bit_cnt_r  <= '0;
      dig_left_r <= '0;
      neg_r      <= 1'b0;
      ovf_r      <= 1'b0;
      started_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      dig_left_r <= dig_left_nxt;
      neg_r      <= neg_nxt;
      ovf_r      <= ovf_nxt;
      started_r  <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == sidec_pkg::ST_CONV) && (bit_cnt_r == '0))
    else $error("accepted transaction did not start conversion");

  a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |=> !busy)
    else $error("sequencer still busy after last character");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sidec_pkg::ST_EMIT) |-> (dig_left_r != '0))
    else $error("digit stream with no digits left");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sidec_pkg::ST_SIGN) |-> neg_r && !started_r)
    else $error("minus sign for a non-negative value or after a digit");

  a_no_output_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == sidec_pkg::ST_SIGN || state_r == sidec_pkg::ST_EMIT))
    else $error("character strobe outside output phase");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb : regression for signed_int_to_decimal_ascii
// Sends signed 64-bit values as start/busy transactions and predicts the
// decimal text of each one: an optional minus sign, then digits most
// significant first, with the last flag on the final character. Every
// character strobed out is checked in order against the prediction. Directed
// corner values come first, then random values under three sender gap
// profiles.
// ----------------------------------------------------------------------------
module tb;

  // One character of predicted text
  typedef struct packed {
    logic [sidec_pkg::CHAR_W-1:0] code;
    logic                         last;
  } ascii_char_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic signed [sidec_pkg::VALUE_W-1:0] in_value;
  logic                                 out_valid;
  logic [sidec_pkg::CHAR_W-1:0]         out_char_code;
  logic                                 out_last_char;

  // Characters still owed by the block, oldest first
  ascii_char_t text_due[$];
  int          mismatch_count;

  signed_int_to_decimal_ascii DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // 4-unit period clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Decimal text of one value, appended to the queue of owed characters.
  // The magnitude is taken unsigned, so the most negative value prints whole.
  // Only the low-order MAX_DIGITS digits survive a buffer smaller than the
  // number, leading zeros included.
  function automatic void queue_decimal_text(input logic signed [sidec_pkg::VALUE_W-1:0] v);
    logic [sidec_pkg::VALUE_W-1:0] mag;
    logic [sidec_pkg::VALUE_W-1:0] rem;
    logic [sidec_pkg::DIGIT_W-1:0] digs [sidec_pkg::MAX_DIGITS];
    int                            ndig;
    logic                          neg;
    ascii_char_t                   ch;
    neg  = v[sidec_pkg::VALUE_W-1];
    mag  = neg ? (~v + 64'd1) : v;
    ndig = 0;
    if (mag == '0) begin
      ch.code = sidec_pkg::CHAR_ZERO;
      ch.last = 1'b1;
      text_due.push_back(ch);
      return;
    end
    while (mag != '0 && ndig < sidec_pkg::MAX_DIGITS) begin
      rem        = mag % 64'd10;
      digs[ndig] = rem[sidec_pkg::DIGIT_W-1:0];
      mag        = mag / 64'd10;
      ndig++;
    end
    if (neg) begin
      ch.code = sidec_pkg::CHAR_MINUS;
      ch.last = 1'b0;
      text_due.push_back(ch);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      ch.code = sidec_pkg::CHAR_ZERO +
                {{(sidec_pkg::CHAR_W - sidec_pkg::DIGIT_W){1'b0}}, digs[i]};
      ch.last = (i == 0);
      text_due.push_back(ch);
    end
  endfunction

  // Random value spread over all digit counts, both signs
  function automatic logic signed [sidec_pkg::VALUE_W-1:0] random_value();
    logic [sidec_pkg::VALUE_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ;                                 // full width, any sign
      1, 2: r = r >> $urandom_range(63);   // spread digit count
      default: r = 64'($urandom_range(1000));
    endcase
    if ($urandom_range(3) != 0 && $urandom_range(1) == 1)
      r = ~r + 64'd1;
    return r;
  endfunction

  // Drive one value and hold start until the block takes it. start stays
  // high on return so back-to-back transactions need no idle gap in start.
  task automatic send_value(input logic signed [sidec_pkg::VALUE_W-1:0] v);
    @(negedge clk);
    start    = 1'b1;
    in_value = v;
    do @(posedge clk); while (busy);
    queue_decimal_text(v);
  endtask

  // Sender gap: start low for a while, mostly short, sometimes long enough
  // to land after busy falls at any point of the conversion
  task automatic sender_gap(input int pct);
    int n;
    if ($urandom_range(99) < pct) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 8);
      @(negedge clk);
      start    = 1'b0;
      in_value = {$urandom, $urandom};
      repeat (n) @(negedge clk);
    end
  endtask

  // Corner values: zero, single digits, decade edges, both extremes
  task automatic test_corner_values();
    logic signed [sidec_pkg::VALUE_W-1:0] corners[$];
    corners = '{
      64'sh0000_0000_0000_0000,            // zero: lone '0'
      64'sh0000_0000_0000_0001,
      64'shFFFF_FFFF_FFFF_FFFF,            // -1
      64'sd9,
      -64'sd9,
      64'sd10,
      -64'sd10,
      64'sd100,
      -64'sd100,
      64'sd12345,
      64'sd999999999999999999,             // 18 nines
      64'sd1000000000000000000,            // 10^18, 19 digits
      -64'sd999999999999999999,
      -64'sd1000000000000000000,
      64'sh7FFF_FFFF_FFFF_FFFF,            // most positive
      64'sh8000_0000_0000_0000,            // most negative, magnitude unsigned
      64'sh8000_0000_0000_0001,
      64'sh5555_5555_5555_5555,
      64'shAAAA_AAAA_AAAA_AAAA,
      64'sd1000000000
    };
    foreach (corners[i]) begin
      send_value(corners[i]);
      sender_gap(30);
    end
  endtask

  task automatic test_random_light_gaps();
    repeat (120) begin
      send_value(random_value());
      sender_gap(21);
    end
  endtask

  task automatic test_random_heavy_gaps();
    repeat (120) begin
      send_value(random_value());
      sender_gap(59);
    end
  endtask

  task automatic test_random_back_to_back();
    repeat (120)
      send_value(random_value());
  endtask

  // Result checker: every strobed character against the oldest owed one
  always @(posedge clk) begin
    ascii_char_t due;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (text_due.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, out_char_code, out_last_char);
          mismatch_count++;
        end else begin
          due = text_due.pop_front();
          if (out_char_code !== due.code) begin
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, due.code, out_char_code);
            mismatch_count++;
          end
          if (out_last_char !== due.last) begin
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, due.last, out_last_char);
            mismatch_count++;
          end
        end
      end else if (out_valid !== 1'b0) begin
        $display("%0t: out_valid mismatch: expected 0 or 1, actual %b",
                 $time, out_valid);
        mismatch_count++;
      end
    end
  end

  // Main sequence
  initial begin
    mismatch_count = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_value       = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_corner_values();
    test_random_light_gaps();
    test_random_heavy_gaps();
    test_random_back_to_back();

    @(negedge clk);
    start = 1'b0;
    // drain owed text, then wait longer than a conversion for strays
    while (text_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0)
      $display("signed_int_to_decimal_ascii regression: pass");
    else
      $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #2000000;
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule
